### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define HFTD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every clock edge, reset included.
`define HFTD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

### hdl/hftd_pkg.sv
// ----------------------------------------------------------------------------
// hftd_pkg
// Types and constants of the tree-walk stream decoder.
// ----------------------------------------------------------------------------
package hftd_pkg;

    localparam int IDX_W     = 9;
    localparam int SYM_W     = 8;
    localparam int CNT_W     = 32;
    localparam int BYTE_BITS = 8;
    localparam int BIT_W     = 3;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;

    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_DATA = 2'd1;
    localparam logic [OP_W-1:0] OP_EMIT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_INDEX   = 1'b1;

    // One node table entry, 27 bits.
    typedef struct packed {
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
        logic [SYM_W-1:0] sym;
        logic             leaf;
    } t_node;

    localparam int NODE_W = $bits(t_node);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_STEP,
        ST_CHILD,
        ST_ROOT,
        ST_FLUSH
    } t_state;

endpackage

### hdl/huffman_tree_stream_decoder.sv
// ----------------------------------------------------------------------------
// huffman_tree_stream_decoder
// Code tree walk over a node table RAM, one table read per stream bit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries one request per item: a node
//   load (writes the table), a compressed byte, or an emit for a tree whose
//   root is a leaf. Output channel (o_valid / i_ready) carries
//   decoded symbols; o_last_of_item marks the last symbol of a request and
//   o_final_symbol the one that completes the configured count.
//   Config writes (i_cfg_we) restart the walk at the root and zero emitted count.
// Walk:
//   A data byte is walked from its top bit down; the walk stops early at the
//   count or at a leaf root. Each bit is one registered node table read
//   (ST_STEP) followed by a decision in ST_CHILD; a mid-byte symbol costs one
//   more read (ST_ROOT) to reload the root entry. A symbol is held until the
//   next one or the end of the request pushes it out.
// Reset: sync, active low; no result pending, count 0, root 0. The node table
//   is not cleared and must be loaded before use.
// Stall: a full output register holds the walk whenever a symbol must move
//   into it; the next request is taken while the last result still waits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module huffman_tree_stream_decoder
    import hftd_pkg::*;
#(
    parameter int NODE_ENTRIES = 512
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input requests
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [OP_W-1:0]      i_operation,
    input  logic [SYM_W-1:0]     i_data_byte,
    input  logic [IDX_W-1:0]     i_node_index,
    input  logic [IDX_W-1:0]     i_left_child,
    input  logic [IDX_W-1:0]     i_right_child,
    input  logic [SYM_W-1:0]     i_node_symbol,
    input  logic                 i_node_is_leaf,
    // decoded symbols
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [SYM_W-1:0]     o_symbol,
    output logic                 o_last_of_item,
    output logic                 o_final_symbol,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int ADDR_W = $clog2(NODE_ENTRIES);

    // control state
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_root, n_root;
    logic [IDX_W-1:0] r_cur, n_cur;
    logic [CNT_W-1:0] r_emitted, n_emitted;
    logic             r_pend_valid, n_pend_valid;
    logic             r_out_valid, n_out_valid;

    // payload
    t_node            r_cur_node, n_cur_node;
    logic [SYM_W-1:0] r_byte, n_byte;
    logic [BIT_W-1:0] r_bit, n_bit;
    logic             r_is_emit, n_is_emit;
    logic             r_rd_oob;
    logic [SYM_W-1:0] r_pend_sym, n_pend_sym;
    logic             r_pend_final, n_pend_final;
    logic [SYM_W-1:0] r_out_sym, n_out_sym;
    logic             r_out_last, n_out_last;
    logic             r_out_final, n_out_final;

    logic                    w_accept;
    logic                    w_out_free;
    logic                    w_cnt_done;
    logic                    w_emit_req;
    logic                    w_stall;
    logic                    w_emit;
    logic                    w_flush;
    logic [SYM_W-1:0]        w_emit_sym;
    logic [IDX_W-1:0]        w_child;
    logic [IDX_W-1:0]        w_rd_idx;
    t_node                   w_rd_node;
    logic [NODE_W-1:0]       w_ram_rdata;
    logic                    w_ram_we;
    logic [IDX_W+ADDR_W-1:0] w_raddr_ext;
    logic [IDX_W+ADDR_W-1:0] w_waddr_ext;
    t_node                   w_wnode;

    assign o_ready    = (r_state == ST_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_cnt_done = (r_emitted >= r_count);
    assign w_child    = r_byte[r_bit] ? r_cur_node.right : r_cur_node.left;

    // entries past the table read as zero
    assign w_rd_node  = r_rd_oob ? '0 : t_node'(w_ram_rdata);

    assign w_emit_req = ((r_state == ST_CHILD) && w_rd_node.leaf) ||
                        ((r_state == ST_STEP) && !w_cnt_done && r_is_emit &&
                         r_cur_node.leaf);
    // a second symbol needs the output register free
    assign w_stall    = w_emit_req && r_pend_valid && !w_out_free;
    assign w_emit     = w_emit_req && !w_stall;
    assign w_flush    = (r_state == ST_FLUSH) && r_pend_valid && w_out_free;
    assign w_emit_sym = (r_state == ST_CHILD) ? w_rd_node.sym : r_cur_node.sym;

    // node table access
    always_comb begin
        w_rd_idx = r_cur;
        if (r_state == ST_STEP) begin
            w_rd_idx = w_child;
        end else if (w_emit) begin
            w_rd_idx = r_root;
        end
    end

    assign w_ram_we    = w_accept && (i_operation == OP_LOAD) &&
                         (32'(i_node_index) < 32'(NODE_ENTRIES));
    assign w_raddr_ext = {{ADDR_W{1'b0}}, w_rd_idx};
    assign w_waddr_ext = {{ADDR_W{1'b0}}, i_node_index};
    assign w_wnode     = '{left: i_left_child, right: i_right_child,
                           sym: i_node_symbol, leaf: i_node_is_leaf};

    hftd_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_ENTRIES)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr_ext[ADDR_W-1:0]),
        .i_wdata (w_wnode),
        .i_raddr (w_raddr_ext[ADDR_W-1:0]),
        .o_rdata (w_ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_operation == OP_DATA || i_operation == OP_EMIT)) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                n_state = ST_STEP;
            end
            ST_STEP: begin
                if (w_cnt_done || r_is_emit || r_cur_node.leaf) begin
                    n_state = ST_FLUSH;
                end else begin
                    n_state = ST_CHILD;
                end
            end
            ST_CHILD: begin
                if (!w_stall) begin
                    if (r_bit == '0) begin
                        n_state = ST_FLUSH;
                    end else if (w_rd_node.leaf) begin
                        n_state = ST_ROOT;
                    end else begin
                        n_state = ST_STEP;
                    end
                end
            end
            ST_ROOT: begin
                n_state = ST_STEP;
            end
            ST_FLUSH: begin
                if (!r_pend_valid || w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_count      = r_count;
        n_root       = r_root;
        n_cur        = r_cur;
        n_emitted    = r_emitted;
        n_cur_node   = r_cur_node;
        n_byte       = r_byte;
        n_bit        = r_bit;
        n_is_emit    = r_is_emit;
        n_pend_valid = r_pend_valid;
        n_pend_sym   = r_pend_sym;
        n_pend_final = r_pend_final;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_sym    = r_out_sym;
        n_out_last   = r_out_last;
        n_out_final  = r_out_final;

        if (w_accept) begin
            n_byte    = i_data_byte;
            n_bit     = BIT_W'(BYTE_BITS - 1);
            n_is_emit = (i_operation == OP_EMIT);
        end

        if ((r_state == ST_FETCH) || (r_state == ST_ROOT) ||
            ((r_state == ST_CHILD) && !w_stall)) begin
            n_cur_node = w_rd_node;
        end

        if ((r_state == ST_STEP) && !w_cnt_done && !r_is_emit && !r_cur_node.leaf) begin
            n_cur = w_child;
        end

        if ((r_state == ST_CHILD) && !w_stall && (r_bit != '0)) begin
            n_bit = r_bit - BIT_W'(1);
        end

        if (w_emit) begin
            if (r_pend_valid) begin
                n_out_valid = 1'b1;
                n_out_sym   = r_pend_sym;
                n_out_last  = 1'b0;
                n_out_final = r_pend_final;
            end
            n_pend_valid = 1'b1;
            n_pend_sym   = w_emit_sym;
            n_pend_final = ((r_emitted + CNT_W'(1)) == r_count);
            n_emitted    = r_emitted + CNT_W'(1);
            n_cur        = r_root;
        end

        if (w_flush) begin
            n_out_valid  = 1'b1;
            n_out_sym    = r_pend_sym;
            n_out_last   = 1'b1;
            n_out_final  = r_pend_final;
            n_pend_valid = 1'b0;
        end

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SYMBOL_COUNT: n_count = i_cfg_data;
                CFG_ROOT_INDEX:   n_root  = i_cfg_data[IDX_W-1:0];
                default:          n_count = r_count;
            endcase
            n_cur     = n_root;
            n_emitted = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_root       <= '0;
            r_cur        <= '0;
            r_emitted    <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_root       <= n_root;
            r_cur        <= n_cur;
            r_emitted    <= n_emitted;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_node   <= n_cur_node;
        r_byte       <= n_byte;
        r_bit        <= n_bit;
        r_is_emit    <= n_is_emit;
        r_rd_oob     <= (32'(w_rd_idx) >= 32'(NODE_ENTRIES));
        r_pend_sym   <= n_pend_sym;
        r_pend_final <= n_pend_final;
        r_out_sym    <= n_out_sym;
        r_out_last   <= n_out_last;
        r_out_final  <= n_out_final;
    end

    assign o_valid        = r_out_valid;
    assign o_symbol       = r_out_sym;
    assign o_last_of_item = r_out_last;
    assign o_final_symbol = r_out_final;

    // assertions
    `HFTD_ASSERT(a_cnt_bound, i_clk, i_rst_n, (r_emitted <= r_count), "emitted count passed the limit")
    `HFTD_ASSERT(a_idle_no_pend, i_clk, i_rst_n, ((r_state == ST_IDLE) |-> !r_pend_valid), "symbol left pending at idle")
    `HFTD_ASSERT(a_final_last, i_clk, i_rst_n, ((o_valid && o_final_symbol) |-> o_last_of_item), "final symbol not last of request")
    `HFTD_ASSERT(a_cnt_step, i_clk, i_rst_n, ((r_emitted != $past(r_emitted)) |-> ((r_emitted == $past(r_emitted) + CNT_W'(1)) || (r_emitted == '0))), "emitted count jumped")
    `HFTD_ASSERT_ALWAYS(a_reset, i_clk, (!i_rst_n |=> ((r_state == ST_IDLE) && !r_out_valid)), "reset did not clear control")

endmodule

### hdl/hftd_ram.sv
// ----------------------------------------------------------------------------
// hftd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module hftd_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
